// File: rtl/ryb_pkg.sv
// ----------------------------------------------------------------------------
// ryb_pkg: shared types and constants
// Coefficients, register indexes and the pixel word of the RGB to YCbCr
// converter with 8x8 block reordering.
// ----------------------------------------------------------------------------
package ryb_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic REG_WIDTH_BLOCKS = 1'b0;
	localparam logic REG_COLOR_MODE   = 1'b1;

	localparam logic [8:0] WIDTH_BLOCKS_RST = 9'd80;
	localparam logic [5:0] IDX_LAST         = 6'd63;

	// Q16 coefficients
	localparam logic signed [17:0] C_Y_R  =  18'sd19595;
	localparam logic signed [17:0] C_Y_G  =  18'sd38470;
	localparam logic signed [17:0] C_Y_B  =  18'sd7471;
	localparam logic signed [17:0] C_CB_R = -18'sd11056;
	localparam logic signed [17:0] C_CB_G = -18'sd21712;
	localparam logic signed [17:0] C_CB_B =  18'sd32768;
	localparam logic signed [17:0] C_CR_R =  18'sd32768;
	localparam logic signed [17:0] C_CR_G = -18'sd27440;
	localparam logic signed [17:0] C_CR_B = -18'sd5328;
	localparam logic signed [25:0] C_OFFSET = 26'sd8388608;

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] cb;
		logic [7:0] cr;
	} ycc_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} rd_state_t;

	function automatic logic signed [25:0] mul_q16(input logic [7:0] v,
			input logic signed [17:0] c);
		logic signed [25:0] a;
		logic signed [25:0] k;
		a = $signed({18'd0, v});
		k = 26'(c);
		return a * k;
	endfunction

	function automatic logic [7:0] clamp_q16(input logic signed [25:0] s);
		logic [7:0] v;
		if (s < 0) begin
			v = 8'd0;
		end else if (s[25:16] > 10'd255) begin
			v = 8'd255;
		end else begin
			v = s[23:16];
		end
		return v;
	endfunction

endpackage

// File: rtl/ryb_queue.sv
// ----------------------------------------------------------------------------
// ryb_queue: block command queue
// Holds the column of each completed block until the readout side takes it.
// Slot contents and valid bits are visible for overwrite checks.
// ----------------------------------------------------------------------------
module ryb_queue #(
	parameter int W = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [W-1:0]             push_col,
	input  logic                     pop,
	output logic                     filled,
	output logic [W-1:0]             head,
	output logic [W-1:0]             ent [ryb_pkg::QDEPTH],
	output logic [ryb_pkg::QDEPTH-1:0] ent_vld
);

	logic [W-1:0]                slot_q [ryb_pkg::QDEPTH];
	logic [ryb_pkg::QDEPTH-1:0]  vld_q;
	logic [ryb_pkg::QAW-1:0]     wr_q;
	logic [ryb_pkg::QAW-1:0]     rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
		end else begin
			if (push) begin
				vld_q[wr_q] <= 1'b1;
				wr_q        <= wr_q + ryb_pkg::QAW'(1);
			end
			if (pop) begin
				vld_q[rd_q] <= 1'b0;
				rd_q        <= rd_q + ryb_pkg::QAW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_col;
		end
	end

	assign filled  = vld_q[rd_q];
	assign head    = slot_q[rd_q];
	assign ent     = slot_q;
	assign ent_vld = vld_q;

endmodule

// File: rtl/ryb_front.sv
// ----------------------------------------------------------------------------
// ryb_front: pixel intake and colour conversion
// Tracks raster position, converts each pixel over two stages, writes the
// band store and queues a block once its bottom-right pixel is written.
// ----------------------------------------------------------------------------
module ryb_front #(
	parameter  int MAX_WIDTH_BLOCKS = 256,
	localparam int BCW = (MAX_WIDTH_BLOCKS > 1) ? $clog2(MAX_WIDTH_BLOCKS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	input  logic                       cfg_write,
	input  logic                       cfg_index,
	input  logic [8:0]                 cfg_data,
	input  logic [BCW-1:0]             q_ent [ryb_pkg::QDEPTH],
	input  logic [ryb_pkg::QDEPTH-1:0] q_vld,
	input  logic                       act_vld,
	input  logic [BCW-1:0]             act_col,
	output logic                       wr_en,
	output logic [BCW+5:0]             wr_addr,
	output ryb_pkg::ycc_t              wr_data,
	output logic                       push,
	output logic [BCW-1:0]             push_col
);

	localparam int EW = BCW + 1;
	localparam int FW = ryb_pkg::QAW + 1;

	logic [8:0]     width_q;
	logic           color_q;
	logic [EW-1:0]  eff_w;

	logic [BCW-1:0] col_q;
	logic [2:0]     px_q;
	logic [2:0]     row_q;
	logic           trig;
	logic           row_end;
	logic           hit;
	logic [FW-1:0]  free;
	logic [FW-1:0]  pend;
	logic           acc;

	logic           vld_s1;
	logic           trig_s1;
	logic           color_s1;
	logic [7:0]     r_s1;
	logic [7:0]     g_s1;
	logic [7:0]     b_s1;
	logic [BCW-1:0] col_s1;
	logic [2:0]     px_s1;
	logic [2:0]     row_s1;

	logic                vld_s2;
	logic                trig_s2;
	logic                color_s2;
	logic [7:0]          r_s2;
	logic [BCW-1:0]      col_s2;
	logic [2:0]          px_s2;
	logic [2:0]          row_s2;
	logic signed [25:0]  p_s2 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ryb_pkg::WIDTH_BLOCKS_RST;
			color_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ryb_pkg::REG_WIDTH_BLOCKS: width_q <= cfg_data;
				ryb_pkg::REG_COLOR_MODE:   color_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == 9'd0) begin
			eff_w = EW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH_BLOCKS)) begin
			eff_w = EW'(MAX_WIDTH_BLOCKS);
		end else begin
			eff_w = EW'(width_q);
		end
	end

	assign trig    = (row_q == 3'd7) && (px_q == 3'd7);
	assign row_end = (px_q == 3'd7) && ((EW'(col_q) + EW'(1)) >= eff_w);

	// hold off a pixel whose block column still awaits readout, or a block's last pixel while the queue has no free slot
	always_comb begin
		hit  = 1'b0;
		free = '0;
		for (int i = 0; i < ryb_pkg::QDEPTH; i++) begin
			if (q_vld[i] && (q_ent[i] == col_q)) hit = 1'b1;
			if (!q_vld[i]) free = free + FW'(1);
		end
		if (act_vld && (act_col == col_q)) hit = 1'b1;
		if (vld_s1 && trig_s1 && (col_s1 == col_q)) hit = 1'b1;
		if (vld_s2 && trig_s2 && (col_s2 == col_q)) hit = 1'b1;
		pend = FW'(vld_s1 && trig_s1) + FW'(vld_s2 && trig_s2);
	end

	assign in_ready = !hit && (!trig || (free > pend));
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			px_q  <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (row_end) begin
				col_q <= '0;
				px_q  <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				px_q <= px_q + 3'd1;
				if (px_q == 3'd7) col_q <= col_q + BCW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			trig_s1  <= trig;
			color_s1 <= color_q;
			r_s1     <= red;
			g_s1     <= green;
			b_s1     <= blue;
			col_s1   <= col_q;
			px_s1    <= px_q;
			row_s1   <= row_q;
		end
	end

	always_ff @(posedge clk) begin
		trig_s2  <= trig_s1;
		color_s2 <= color_s1;
		r_s2     <= r_s1;
		col_s2   <= col_s1;
		px_s2    <= px_s1;
		row_s2   <= row_s1;
		p_s2[0]  <= ryb_pkg::mul_q16(r_s1, ryb_pkg::C_Y_R);
		p_s2[1]  <= ryb_pkg::mul_q16(g_s1, ryb_pkg::C_Y_G);
		p_s2[2]  <= ryb_pkg::mul_q16(b_s1, ryb_pkg::C_Y_B);
		p_s2[3]  <= ryb_pkg::mul_q16(r_s1, ryb_pkg::C_CB_R);
		p_s2[4]  <= ryb_pkg::mul_q16(g_s1, ryb_pkg::C_CB_G);
		p_s2[5]  <= ryb_pkg::mul_q16(b_s1, ryb_pkg::C_CB_B);
		p_s2[6]  <= ryb_pkg::mul_q16(r_s1, ryb_pkg::C_CR_R);
		p_s2[7]  <= ryb_pkg::mul_q16(g_s1, ryb_pkg::C_CR_G);
		p_s2[8]  <= ryb_pkg::mul_q16(b_s1, ryb_pkg::C_CR_B);
	end

	always_comb begin
		if (color_s2) begin
			wr_data.y  = ryb_pkg::clamp_q16(p_s2[0] + p_s2[1] + p_s2[2]);
			wr_data.cb = ryb_pkg::clamp_q16(p_s2[3] + p_s2[4] + p_s2[5]
				+ ryb_pkg::C_OFFSET);
			wr_data.cr = ryb_pkg::clamp_q16(p_s2[6] + p_s2[7] + p_s2[8]
				+ ryb_pkg::C_OFFSET);
		end else begin
			wr_data.y  = r_s2;
			wr_data.cb = 8'd0;
			wr_data.cr = 8'd0;
		end
	end

	assign wr_en    = vld_s2;
	assign wr_addr  = {row_s2, col_s2, px_s2};
	assign push     = vld_s2 && trig_s2;
	assign push_col = col_s2;

endmodule

// File: rtl/ryb_back.sv
// ----------------------------------------------------------------------------
// ryb_back: band store and block readout
// Owns the band store; reads the 64 pixels of each queued block in
// row-major order through a registered read and an output register.
// ----------------------------------------------------------------------------
module ryb_back #(
	parameter  int MAX_WIDTH_BLOCKS = 256,
	localparam int BCW = (MAX_WIDTH_BLOCKS > 1) ? $clog2(MAX_WIDTH_BLOCKS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [BCW+5:0] wr_addr,
	input  ryb_pkg::ycc_t  wr_data,
	input  logic           q_filled,
	input  logic [BCW-1:0] q_head,
	output logic           q_pop,
	output logic           act_vld,
	output logic [BCW-1:0] act_col,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     luma,
	output logic [7:0]     chroma_blue,
	output logic [7:0]     chroma_red,
	output logic           block_end
);

	localparam int AW    = BCW + 6;
	localparam int DEPTH = 1 << AW;

	ryb_pkg::ycc_t band_mem [DEPTH];

	ryb_pkg::rd_state_t state_q;
	ryb_pkg::rd_state_t state_d;
	logic [5:0]         idx_q;
	logic [BCW-1:0]     col_q;
	logic               issue;
	logic               out_load;
	logic               s1_free;

	ryb_pkg::ycc_t      rdata_s1;
	logic               rvld_s1;
	logic               rlast_s1;
	ryb_pkg::ycc_t      out_q;
	logic               out_vld_q;
	logic               out_last_q;

	assign out_load = !out_vld_q || out_ready;
	assign s1_free  = !rvld_s1 || out_load;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ryb_pkg::ST_IDLE: if (q_filled) state_d = ryb_pkg::ST_READ;
			ryb_pkg::ST_READ: begin
				if (issue && (idx_q == ryb_pkg::IDX_LAST) && !q_filled)
					state_d = ryb_pkg::ST_IDLE;
			end
			default: state_d = ryb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		issue = 1'b0;
		q_pop = 1'b0;
		unique case (state_q)
			ryb_pkg::ST_IDLE: q_pop = q_filled;
			ryb_pkg::ST_READ: begin
				issue = s1_free;
				q_pop = q_filled && s1_free && (idx_q == ryb_pkg::IDX_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ryb_pkg::ST_IDLE;
			idx_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				idx_q <= '0;
				col_q <= q_head;
			end else if (issue) begin
				idx_q <= idx_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			band_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= band_mem[{idx_q[5:3], col_q, idx_q[2:0]}];
			rlast_s1 <= (idx_q == ryb_pkg::IDX_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (issue) begin
				rvld_s1 <= 1'b1;
			end else if (out_load) begin
				rvld_s1 <= 1'b0;
			end
			if (out_load) out_vld_q <= rvld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && rvld_s1) begin
			out_q      <= rdata_s1;
			out_last_q <= rlast_s1;
		end
	end

	assign act_vld     = (state_q == ryb_pkg::ST_READ);
	assign act_col     = col_q;
	assign out_valid   = out_vld_q;
	assign luma        = out_q.y;
	assign chroma_blue = out_q.cb;
	assign chroma_red  = out_q.cr;
	assign block_end   = out_last_q;

endmodule

// File: rtl/rgb_to_ycbcr_block_reorder.sv
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_block_reorder: RGB to YCbCr converter with 8x8 block reorder
// Raster pixels in, converted 8x8 blocks out in row-major order.
// ----------------------------------------------------------------------------
// Input beats (red, green, blue) are taken in raster order on in_valid and
// in_ready; output beats (luma, chroma_blue, chroma_red, block_end) leave on
// out_valid and out_ready. cfg_write with cfg_index and cfg_data sets the
// width in blocks or the colour mode; the user must do so only while the
// block is idle, as the block does not enforce it. Intake takes one pixel a
// cycle while in_ready is high. Each pixel passes two conversion stages before
// it is written to the band store; a block is queued when its bottom-right
// pixel is written. Readout gives one beat a cycle while out_ready is high,
// 64 per block, set by the single read port of the band store. in_ready drops
// while the pixel would overwrite a block still awaiting readout, or while a
// block's last pixel has no room in the four-entry block queue; with narrow
// images this paces intake to the readout of each block. A receiver stall
// holds the output register and stops readout; intake runs on until the
// queue or an overwrite check stops it.
// Reset returns to row 0, column 0, width 80 blocks, colour mode; the band
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_block_reorder #(
	parameter int MAX_WIDTH_BLOCKS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] luma,
	output logic [7:0] chroma_blue,
	output logic [7:0] chroma_red,
	output logic       block_end,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);

	localparam int BCW = (MAX_WIDTH_BLOCKS > 1) ? $clog2(MAX_WIDTH_BLOCKS) : 1;

	logic [BCW-1:0]             q_ent [ryb_pkg::QDEPTH];
	logic [ryb_pkg::QDEPTH-1:0] q_vld;
	logic                       q_filled;
	logic [BCW-1:0]             q_head;
	logic                       q_pop;
	logic                       act_vld;
	logic [BCW-1:0]             act_col;
	logic                       wr_en;
	logic [BCW+5:0]             wr_addr;
	ryb_pkg::ycc_t              wr_data;
	logic                       push;
	logic [BCW-1:0]             push_col;

	ryb_front #(
		.MAX_WIDTH_BLOCKS(MAX_WIDTH_BLOCKS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_ent    (q_ent),
		.q_vld    (q_vld),
		.act_vld  (act_vld),
		.act_col  (act_col),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.push     (push),
		.push_col (push_col)
	);

	ryb_queue #(
		.W(BCW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_col(push_col),
		.pop     (q_pop),
		.filled  (q_filled),
		.head    (q_head),
		.ent     (q_ent),
		.ent_vld (q_vld)
	);

	ryb_back #(
		.MAX_WIDTH_BLOCKS(MAX_WIDTH_BLOCKS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.q_filled   (q_filled),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.act_vld    (act_vld),
		.act_col    (act_col),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.luma       (luma),
		.chroma_blue(chroma_blue),
		.chroma_red (chroma_red),
		.block_end  (block_end)
	);

endmodule
